// ===== rtl/core/rgb2yuv_pkg.sv =====
`timescale 1ns / 1ps

package rgb2yuv_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_W        = 10;
  localparam int CFG_IDX_W    = 1;
  localparam int LUMA_OFF_W   = 20;
  localparam int CHROMA_OFF_W = 18;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 32;
  localparam int OUT_USER_W   = 3;
  localparam int QUEUE_DEPTH  = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 10'd320;
  localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 10'd240;

  // BT.601 integer coefficients, magnitudes; signs are applied in the datapath
  localparam int Y_R = 66;
  localparam int Y_G = 129;
  localparam int Y_B = 25;
  localparam int U_R = 38;
  localparam int U_G = 74;
  localparam int U_B = 112;
  localparam int V_R = 112;
  localparam int V_G = 94;
  localparam int V_B = 18;
  localparam logic [PIX_W-1:0] Y_OFFSET = 8'd16;
  // 128 << 8: keeps the chroma sum non-negative so bits [15:8] give floor + 128
  localparam int CHROMA_BIAS = 32768;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef struct packed {
    logic [PIX_W-1:0]        y;
    logic [PIX_W-1:0]        u;
    logic [PIX_W-1:0]        v;
    logic [LUMA_OFF_W-1:0]   luma_off;
    logic [CHROMA_OFF_W-1:0] chroma_off;
    logic                    has_chroma;
    logic                    frame_end;
  } pix_entry_t;

  // Zero counts as one; anything above the cap saturates to it
  function automatic logic [CFG_W-1:0] clamp_half(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > cap) begin
      res = cap;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/rgb_to_yuv420p_converter_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports (tvalid/tready/...)      Payload
// in_       slave      in_tdata[23:0]                 red, green, blue
// out_      master     out_tdata[31:0], tuser, tlast  offset, sample_value;
//                                                     tuser plane, last_of_pixel
// cfg_      write      cfg_wr_en, cfg_index, wdata    half_width, half_height
//
// A pixel is taken in any cycle the four-entry queue has room; results leave
// one per cycle while out_tready is high, from a registered output stage, so
// a pixel on an even row and even column yields three samples (Y, U, V) and
// any other one; at 1.5 samples per pixel the output port sets the pace.
// Reset (synchronous, rst_n low) clears the position counters, offsets, queue
// and output valid, and loads half_width 320 and half_height 240.
// out_tready low holds the output register; the queue then absorbs up to four
// pixels before in_tready drops.

module rgb_to_yuv420p_converter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]       cfg_wdata,
  // Pixel input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rgb2yuv_pkg::IN_DATA_W-1:0]   in_tdata,   // red, green, blue
  // Sample output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rgb2yuv_pkg::OUT_DATA_W-1:0]  out_tdata,  // offset[19:0], sample_value, 4'b0
  output logic [rgb2yuv_pkg::OUT_USER_W-1:0]  out_tuser,  // plane[1:0], last_of_pixel
  output logic                                out_tlast   // last_of_frame
);
  import rgb2yuv_pkg::*;

  pix_entry_t            entry_in, entry_head;
  logic [$bits(pix_entry_t)-1:0] head_bits;
  logic                  push, pop, q_full, q_empty;
  plane_t                plane;
  logic [LUMA_OFF_W-1:0] offset;
  logic [PIX_W-1:0]      sample_value;
  logic                  last_of_pixel;

  // Front: count pixels, classify each one and compute its Y/U/V bytes
  rgb2yuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .queue_full (q_full),
    .push       (push),
    .entry      (entry_in)
  );

  // Decouple pixel intake from sample emission
  rgb2yuv_queue #(
    .WIDTH ($bits(pix_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (entry_in),
    .pop   (pop),
    .rdata (head_bits),
    .full  (q_full),
    .empty (q_empty)
  );

  assign entry_head = pix_entry_t'(head_bits);

  // Back: expand each queued pixel into one or three sample transactions
  rgb2yuv_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (entry_head),
    .queue_empty   (q_empty),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .plane         (plane),
    .offset        (offset),
    .sample_value  (sample_value),
    .last_of_pixel (last_of_pixel),
    .last_of_frame (out_tlast)
  );

  assign out_tdata = {4'b0000, sample_value, offset};
  assign out_tuser = {last_of_pixel, plane};

endmodule

// ===== rtl/core/rgb2yuv_front.sv =====
`timescale 1ns / 1ps

module rgb2yuv_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rgb2yuv_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                                queue_full,
  output logic                                push,
  output rgb2yuv_pkg::pix_entry_t             entry
);
  import rgb2yuv_pkg::*;

  localparam int CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW_HI  = MAX_WIDTH / 2;
  localparam int HH_HI  = MAX_HEIGHT / 2;
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] HW_CAP = CFG_W'((HW_HI > CFG_MAX) ? CFG_MAX : HW_HI);
  localparam logic [CFG_W-1:0] HH_CAP = CFG_W'((HH_HI > CFG_MAX) ? CFG_MAX : HH_HI);
  // Compare width covers both counter + 1 and twice a half size
  localparam int CMPW_C = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;
  localparam int CMPW_R = (RW + 1 > CFG_W + 1) ? RW + 1 : CFG_W + 1;

  logic [CFG_W-1:0]        half_width_r;
  logic [CFG_W-1:0]        half_height_r;
  logic [CW-1:0]           col_r;
  logic [RW-1:0]           row_r;
  logic [LUMA_OFF_W-1:0]   luma_off_r;
  logic [CHROMA_OFF_W-1:0] chroma_off_r;

  logic [PIX_W-1:0]  red, green, blue;
  logic [15:0]       y_sum;
  logic [16:0]       u_sum;
  logic [16:0]       v_sum;
  logic [CFG_W-1:0]  hw_eff, hh_eff;
  logic [CMPW_C-1:0] col_p1, width_full;
  logic [CMPW_R-1:0] row_p1, height_full;
  logic              row_end, frame_end, has_chroma;

  assign red   = in_tdata[7:0];
  assign green = in_tdata[15:8];
  assign blue  = in_tdata[23:16];

  assign in_tready = !queue_full;
  assign push      = in_tvalid && !queue_full;

  assign y_sum = 16'(Y_R * red + Y_G * green + Y_B * blue);
  assign u_sum = 17'(CHROMA_BIAS + U_B * blue - U_R * red - U_G * green);
  assign v_sum = 17'(CHROMA_BIAS + V_R * red - V_G * green - V_B * blue);

  assign hw_eff      = clamp_half(half_width_r, HW_CAP);
  assign hh_eff      = clamp_half(half_height_r, HH_CAP);
  assign col_p1      = CMPW_C'(col_r) + CMPW_C'(1);
  assign row_p1      = CMPW_R'(row_r) + CMPW_R'(1);
  assign width_full  = CMPW_C'({hw_eff, 1'b0});
  assign height_full = CMPW_R'({hh_eff, 1'b0});
  assign row_end     = col_p1 >= width_full;
  assign frame_end   = row_end && (row_p1 >= height_full);
  assign has_chroma  = !row_r[0] && !col_r[0];

  always_comb begin
    entry.y          = y_sum[15:8] + Y_OFFSET;
    entry.u          = u_sum[15:8];
    entry.v          = v_sum[15:8];
    entry.luma_off   = luma_off_r;
    entry.chroma_off = chroma_off_r;
    entry.has_chroma = has_chroma;
    entry.frame_end  = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r  <= HALF_WIDTH_RST;
      half_height_r <= HALF_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HALF_WIDTH:  half_width_r  <= cfg_wdata;
        CFG_HALF_HEIGHT: half_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      luma_off_r   <= '0;
      chroma_off_r <= '0;
    end else if (push) begin
      if (frame_end) begin
        col_r        <= '0;
        row_r        <= '0;
        luma_off_r   <= '0;
        chroma_off_r <= '0;
      end else begin
        luma_off_r <= luma_off_r + 1'b1;
        if (has_chroma) begin
          chroma_off_r <= chroma_off_r + 1'b1;
        end
        if (row_end) begin
          col_r <= '0;
          row_r <= row_p1[RW-1:0];
        end else begin
          col_r <= col_p1[CW-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/core/rgb2yuv_queue.sv =====
`timescale 1ns / 1ps

module rgb2yuv_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;

  assign full  = count_r == (AW + 1)'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/rgb2yuv_back.sv =====
`timescale 1ns / 1ps

module rgb2yuv_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rgb2yuv_pkg::pix_entry_t              head,
  input  logic                                 queue_empty,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rgb2yuv_pkg::plane_t                  plane,
  output logic [rgb2yuv_pkg::LUMA_OFF_W-1:0]   offset,
  output logic [rgb2yuv_pkg::PIX_W-1:0]        sample_value,
  output logic                                 last_of_pixel,
  output logic                                 last_of_frame
);
  import rgb2yuv_pkg::*;

  plane_t                phase_r, phase_nxt;
  logic                  out_valid_r;
  plane_t                plane_r;
  logic [LUMA_OFF_W-1:0] offset_r;
  logic [PIX_W-1:0]      sample_r;
  logic                  lp_r, lf_r;

  logic                  load, take, last_res;
  logic [LUMA_OFF_W-1:0] offset_sel;
  logic [PIX_W-1:0]      sample_sel;
  logic                  lp_sel, lf_sel;

  assign load = !out_valid_r || out_ready;
  assign take = load && !queue_empty;

  always_comb begin
    last_res   = !head.has_chroma || (phase_r == PLANE_V);
    pop        = take && last_res;
    phase_nxt  = phase_r;
    offset_sel = head.luma_off;
    sample_sel = head.y;
    lp_sel     = !head.has_chroma;
    lf_sel     = !head.has_chroma && head.frame_end;
    case (phase_r)
      PLANE_Y: begin
        offset_sel = head.luma_off;
        sample_sel = head.y;
        lp_sel     = !head.has_chroma;
        lf_sel     = !head.has_chroma && head.frame_end;
      end
      PLANE_U: begin
        offset_sel = LUMA_OFF_W'(head.chroma_off);
        sample_sel = head.u;
        lp_sel     = 1'b0;
        lf_sel     = 1'b0;
      end
      PLANE_V: begin
        offset_sel = LUMA_OFF_W'(head.chroma_off);
        sample_sel = head.v;
        lp_sel     = 1'b1;
        lf_sel     = head.frame_end;
      end
      default: ;
    endcase
    if (take) begin
      if (last_res) begin
        phase_nxt = PLANE_Y;
      end else begin
        case (phase_r)
          PLANE_Y: phase_nxt = PLANE_U;
          PLANE_U: phase_nxt = PLANE_V;
          default: phase_nxt = PLANE_Y;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PLANE_Y;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= !queue_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      plane_r  <= phase_r;
      offset_r <= offset_sel;
      sample_r <= sample_sel;
      lp_r     <= lp_sel;
      lf_r     <= lf_sel;
    end
  end

  assign out_valid     = out_valid_r;
  assign plane         = plane_r;
  assign offset        = offset_r;
  assign sample_value  = sample_r;
  assign last_of_pixel = lp_r;
  assign last_of_frame = lf_r;

endmodule
